@@ design/buddy_block_allocator_unit_macros.svh @@
// Assertion helpers for the allocator RTL.
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk and held off while rst_n is low.
`define BBA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and held off while rst_n is low.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bba_pkg.sv @@
package bba_pkg;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_ORD,
    ST_A_SCAN,
    ST_A_POP,
    ST_A_SPLIT,
    ST_A_PUSH,
    ST_F_CHK,
    ST_F_MAP,
    ST_F_PUSH,
    ST_F_LOOP,
    ST_F_RD,
    ST_F_CMP,
    ST_F_MV_RD,
    ST_F_MV_WR,
    ST_F_MERGE,
    ST_DONE
  } bba_state_t;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_NO_BLOCK = 2'd1;
  localparam logic [1:0] STS_BAD_ADDR = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [15:0] alloc_size;
    logic [9:0]  free_addr;
  } bba_req_t;

  typedef struct packed {
    logic [9:0] block_addr;
    logic [1:0] status;
  } bba_rsp_t;

  typedef struct packed {
    logic start;
    logic rsp_ack;
  } bba_ctl_in_t;

  typedef struct packed {
    logic idle;
    logic rsp_valid;
  } bba_ctl_out_t;

endpackage

@@ design/bba_ram.sv @@
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/bba_seq.sv @@
module bba_seq #(
  parameter int MIN_ORDER = 4,
  parameter int MAX_ORDER = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bba_pkg::bba_ctl_in_t    ctl_i,
  input  bba_pkg::bba_req_t       req_i,
  output bba_pkg::bba_ctl_out_t   ctl_o,
  output bba_pkg::bba_rsp_t       rsp_o,
  output logic                    ent_we,
  output logic [$clog2(2*(1 << (MAX_ORDER-MIN_ORDER)))-1:0] ent_waddr,
  output logic [MAX_ORDER-1:0]    ent_wdata,
  output logic [$clog2(2*(1 << (MAX_ORDER-MIN_ORDER)))-1:0] ent_raddr,
  input  logic [MAX_ORDER-1:0]    ent_rdata,
  output logic                    map_we,
  output logic [(((1 << (MAX_ORDER-MIN_ORDER)) > 1) ?
                 $clog2(1 << (MAX_ORDER-MIN_ORDER)) : 1)-1:0] map_waddr,
  output logic [$clog2(MAX_ORDER-MIN_ORDER+2)-1:0] map_wdata,
  output logic [(((1 << (MAX_ORDER-MIN_ORDER)) > 1) ?
                 $clog2(1 << (MAX_ORDER-MIN_ORDER)) : 1)-1:0] map_raddr,
  input  logic [$clog2(MAX_ORDER-MIN_ORDER+2)-1:0] map_rdata
);

  import bba_pkg::*;

  localparam int NUM   = MAX_ORDER - MIN_ORDER + 1;
  localparam int SLOTS = 1 << (MAX_ORDER - MIN_ORDER);
  localparam int DEPTH = 2 * SLOTS;
  localparam int EW    = $clog2(DEPTH);
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int AW    = MAX_ORDER;
  localparam int LW    = $clog2(SLOTS + 1);
  localparam int KW    = $clog2(NUM + 1);
  localparam int KIW   = (NUM > 1) ? $clog2(NUM) : 1;
  localparam int MW    = $clog2(NUM + 1);
  localparam int OW    = $clog2(MAX_ORDER + 2);

  function automatic logic [EW-1:0] f_base(input logic [KW-1:0] k);
    return EW'(DEPTH - (DEPTH >> k));
  endfunction

  function automatic logic [LW-1:0] f_cap(input logic [KW-1:0] k);
    return LW'(SLOTS >> k);
  endfunction

  bba_state_t      state_r, state_nxt;
  logic [15:0]     size_r, size_nxt;
  logic [9:0]      faddr_r, faddr_nxt;
  logic            mode_r, mode_nxt;
  logic [OW-1:0]   ord_r, ord_nxt;
  logic [KW-1:0]   lvl_r, lvl_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [AW-1:0]   bud_r, bud_nxt;
  logic            phase_r, phase_nxt;
  logic [LW-1:0]   idx_r, idx_nxt;
  logic [SW-1:0]   cnt_r, cnt_nxt;
  logic [9:0]      rsp_addr_r, rsp_addr_nxt;
  logic [1:0]      rsp_sts_r, rsp_sts_nxt;
  logic [LW-1:0]   lens_r   [NUM];
  logic [LW-1:0]   lens_nxt [NUM];

  logic [KIW-1:0]  kx;
  logic            k_valid;
  logic [LW-1:0]   len_cur;
  logic [LW-1:0]   cap_cur;
  logic [EW-1:0]   base_cur;
  logic [AW-1:0]   half;
  logic            size_fits;
  logic            ord_over;
  logic            addr_bad;
  logic [SW-1:0]   req_slot;
  logic [SW-1:0]   blk_slot;
  logic            map_bad;
  logic            hit;
  logic            top_lvl;
  logic            shift_more;
  logic            init_last;

  assign kx         = k_r[KIW-1:0];
  assign k_valid    = 32'(k_r) < NUM;
  assign len_cur    = k_valid ? lens_r[kx] : '0;
  assign cap_cur    = f_cap(k_r);
  assign base_cur   = f_base(k_r);
  assign half       = AW'(32'(1) << (32'(k_r) + MIN_ORDER));
  assign size_fits  = (33'(1) << ord_r) >= 33'(size_r);
  assign ord_over   = 32'(ord_r) > MAX_ORDER;
  assign addr_bad   = (32'(faddr_r) >= (32'(1) << MAX_ORDER)) ||
                      ((32'(faddr_r) & ((32'(1) << MIN_ORDER) - 1)) != 0);
  assign req_slot   = SW'(32'(faddr_r) >> MIN_ORDER);
  assign blk_slot   = SW'(32'(addr_r) >> MIN_ORDER);
  assign map_bad    = (map_rdata == '0) || (32'(map_rdata) > NUM);
  assign hit        = ent_rdata == (phase_r ? addr_r : bud_r);
  assign top_lvl    = (32'(k_r) + 1) >= NUM;
  assign shift_more = (32'(idx_r) + 1) < 32'(len_cur);
  assign init_last  = 32'(cnt_r) == SLOTS - 1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:    if (init_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (ctl_i.start) begin
          state_nxt = (req_i.mode == MODE_FREE) ? ST_F_CHK : ST_A_ORD;
        end
      end
      ST_A_ORD: begin
        if (ord_over) state_nxt = ST_DONE;
        else if (size_fits) state_nxt = ST_A_SCAN;
      end
      ST_A_SCAN: begin
        if (!k_valid) state_nxt = ST_DONE;
        else if (len_cur != '0) state_nxt = ST_A_POP;
      end
      ST_A_POP:   state_nxt = ST_A_SPLIT;
      ST_A_SPLIT: state_nxt = (k_r > lvl_r) ? ST_A_PUSH : ST_DONE;
      ST_A_PUSH:  state_nxt = ST_A_SPLIT;
      ST_F_CHK:   state_nxt = addr_bad ? ST_DONE : ST_F_MAP;
      ST_F_MAP:   state_nxt = map_bad ? ST_DONE : ST_F_PUSH;
      ST_F_PUSH:  state_nxt = ST_F_LOOP;
      ST_F_LOOP:  state_nxt = top_lvl ? ST_DONE : ST_F_RD;
      ST_F_RD: begin
        if (idx_r == '0) state_nxt = phase_r ? ST_F_MERGE : ST_DONE;
        else state_nxt = ST_F_CMP;
      end
      ST_F_CMP:   state_nxt = hit ? ST_F_MV_RD : ST_F_RD;
      ST_F_MV_RD: begin
        if (shift_more) state_nxt = ST_F_MV_WR;
        else state_nxt = phase_r ? ST_F_MERGE : ST_F_RD;
      end
      ST_F_MV_WR: state_nxt = ST_F_MV_RD;
      ST_F_MERGE: state_nxt = ST_F_PUSH;
      ST_DONE:    if (ctl_i.rsp_ack) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    size_nxt     = size_r;
    faddr_nxt    = faddr_r;
    mode_nxt     = mode_r;
    ord_nxt      = ord_r;
    lvl_nxt      = lvl_r;
    k_nxt        = k_r;
    addr_nxt     = addr_r;
    bud_nxt      = bud_r;
    phase_nxt    = phase_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    rsp_addr_nxt = rsp_addr_r;
    rsp_sts_nxt  = rsp_sts_r;
    lens_nxt     = lens_r;
    ent_we       = 1'b0;
    ent_waddr    = base_cur + EW'(len_cur);
    ent_wdata    = addr_r;
    ent_raddr    = base_cur;
    map_we       = 1'b0;
    map_waddr    = blk_slot;
    map_wdata    = '0;
    map_raddr    = req_slot;
    unique case (state_r)
      ST_INIT: begin
        map_we    = 1'b1;
        map_waddr = cnt_r;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == '0) begin
          ent_we    = 1'b1;
          ent_waddr = f_base(KW'(NUM - 1));
          ent_wdata = '0;
        end
      end
      ST_IDLE: begin
        if (ctl_i.start) begin
          mode_nxt     = req_i.mode;
          size_nxt     = req_i.alloc_size;
          faddr_nxt    = req_i.free_addr;
          ord_nxt      = OW'(MIN_ORDER);
          rsp_addr_nxt = '0;
          rsp_sts_nxt  = STS_OK;
        end
      end
      ST_A_ORD: begin
        if (ord_over) begin
          rsp_sts_nxt = STS_NO_BLOCK;
        end else if (size_fits) begin
          lvl_nxt = KW'(32'(ord_r) - MIN_ORDER);
          k_nxt   = KW'(32'(ord_r) - MIN_ORDER);
        end else begin
          ord_nxt = ord_r + 1'b1;
        end
      end
      ST_A_SCAN: begin
        if (!k_valid) begin
          rsp_sts_nxt = STS_NO_BLOCK;
        end else if (len_cur != '0) begin
          lens_nxt[kx] = len_cur - 1'b1;
          ent_raddr    = base_cur + EW'(len_cur - 1'b1);
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_A_POP: addr_nxt = ent_rdata;
      ST_A_SPLIT: begin
        if (k_r > lvl_r) begin
          k_nxt = k_r - 1'b1;
        end else begin
          map_we       = 1'b1;
          map_wdata    = MW'(32'(lvl_r) + 1);
          rsp_addr_nxt = 10'(32'(addr_r));
        end
      end
      ST_A_PUSH: begin
        ent_wdata = addr_r + half;
        if (len_cur < cap_cur) begin
          ent_we       = 1'b1;
          lens_nxt[kx] = len_cur + 1'b1;
        end
      end
      ST_F_CHK: begin
        if (addr_bad) rsp_sts_nxt = STS_BAD_ADDR;
        addr_nxt = AW'(32'(faddr_r));
      end
      ST_F_MAP: begin
        if (map_bad) begin
          rsp_sts_nxt = STS_BAD_ADDR;
        end else begin
          map_we    = 1'b1;
          map_waddr = req_slot;
          k_nxt     = KW'(map_rdata - 1'b1);
        end
      end
      ST_F_PUSH: begin
        if (len_cur < cap_cur) begin
          ent_we       = 1'b1;
          lens_nxt[kx] = len_cur + 1'b1;
        end
      end
      ST_F_LOOP: begin
        bud_nxt   = addr_r ^ half;
        phase_nxt = 1'b0;
        idx_nxt   = len_cur;
      end
      ST_F_RD: ent_raddr = base_cur + EW'(idx_r - 1'b1);
      ST_F_CMP: idx_nxt = idx_r - 1'b1;
      ST_F_MV_RD: begin
        if (shift_more) begin
          ent_raddr = base_cur + EW'(idx_r + 1'b1);
        end else begin
          lens_nxt[kx] = len_cur - 1'b1;
          if (!phase_r) begin
            phase_nxt = 1'b1;
            idx_nxt   = len_cur - 1'b1;
          end
        end
      end
      ST_F_MV_WR: begin
        ent_we    = 1'b1;
        ent_waddr = base_cur + EW'(idx_r);
        ent_wdata = ent_rdata;
        idx_nxt   = idx_r + 1'b1;
      end
      ST_F_MERGE: begin
        addr_nxt = (addr_r < bud_r) ? addr_r : bud_r;
        k_nxt    = k_r + 1'b1;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      cnt_r   <= '0;
      for (int i = 0; i < NUM; i++) begin
        lens_r[i] <= (i == NUM - 1) ? LW'(1) : '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      lens_r  <= lens_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    faddr_r    <= faddr_nxt;
    mode_r     <= mode_nxt;
    ord_r      <= ord_nxt;
    lvl_r      <= lvl_nxt;
    k_r        <= k_nxt;
    addr_r     <= addr_nxt;
    bud_r      <= bud_nxt;
    phase_r    <= phase_nxt;
    idx_r      <= idx_nxt;
    rsp_addr_r <= rsp_addr_nxt;
    rsp_sts_r  <= rsp_sts_nxt;
  end

  assign ctl_o.idle       = state_r == ST_IDLE;
  assign ctl_o.rsp_valid  = state_r == ST_DONE;
  assign rsp_o.block_addr = (mode_r == MODE_ALLOC) ? rsp_addr_r : '0;
  assign rsp_o.status     = rsp_sts_r;

endmodule

@@ design/buddy_block_allocator_unit.sv @@
// Buddy allocator: one request at a time; a result is registered once the sequencer ends
// and the output register is empty or draining. Allocate steps the order up to fit the size,
// scans the free lists upward and splits down; free checks the address, reads the order map,
// pushes the block, then per level searches for the buddy, shifts entries and merges. No overlap.
// Reset (rst_n low, synchronous) then a clearing pass over all 2^(MAX_ORDER-MIN_ORDER)
// slots of the order map; in_ready stays low during that pass.
`include "buddy_block_allocator_unit_macros.svh"

module buddy_block_allocator_unit #(
  parameter int MIN_ORDER = 4,
  parameter int MAX_ORDER = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [15:0] in_alloc_size,
  input  logic [9:0]  in_free_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_block_addr,
  output logic [1:0]  out_status
);

  import bba_pkg::*;

  localparam int NUM   = MAX_ORDER - MIN_ORDER + 1;
  localparam int SLOTS = 1 << (MAX_ORDER - MIN_ORDER);
  localparam int DEPTH = 2 * SLOTS;
  localparam int EW    = $clog2(DEPTH);
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MW    = $clog2(NUM + 1);

  bba_ctl_in_t  ctl_in;
  bba_ctl_out_t ctl_out;
  bba_req_t     req;
  bba_rsp_t     rsp;

  logic                 ent_we;
  logic [EW-1:0]        ent_waddr;
  logic [MAX_ORDER-1:0] ent_wdata;
  logic [EW-1:0]        ent_raddr;
  logic [MAX_ORDER-1:0] ent_rdata;
  logic                 map_we;
  logic [SW-1:0]        map_waddr;
  logic [MW-1:0]        map_wdata;
  logic [SW-1:0]        map_raddr;
  logic [MW-1:0]        map_rdata;

  logic       out_valid_r, out_valid_nxt;
  logic [9:0] out_addr_r, out_addr_nxt;
  logic [1:0] out_sts_r, out_sts_nxt;
  logic       in_fire;
  logic       rsp_take;

  // Take a new request only when the sequencer sits idle.
  assign in_ready = ctl_out.idle;
  assign in_fire  = in_valid && in_ready;

  // Move a finished result into the output register when it is empty or draining.
  assign rsp_take = ctl_out.rsp_valid && (!out_valid_r || out_ready);

  assign req.mode       = in_mode;
  assign req.alloc_size = in_alloc_size;
  assign req.free_addr  = in_free_addr;

  assign ctl_in.start   = in_fire;
  assign ctl_in.rsp_ack = rsp_take;

  // Sequencer: size-to-order search, free-list scan, split, lookup and merge.
  bba_seq #(
    .MIN_ORDER (MIN_ORDER),
    .MAX_ORDER (MAX_ORDER)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl_in),
    .req_i     (req),
    .ctl_o     (ctl_out),
    .rsp_o     (rsp),
    .ent_we    (ent_we),
    .ent_waddr (ent_waddr),
    .ent_wdata (ent_wdata),
    .ent_raddr (ent_raddr),
    .ent_rdata (ent_rdata),
    .map_we    (map_we),
    .map_waddr (map_waddr),
    .map_wdata (map_wdata),
    .map_raddr (map_raddr),
    .map_rdata (map_rdata)
  );

  // Free-list stacks, one region per order, packed back to back.
  bba_ram #(
    .WIDTH (MAX_ORDER),
    .DEPTH (DEPTH)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // Level plus one of the allocated block starting at each minimum-size slot, zero if none.
  bba_ram #(
    .WIDTH (MW),
    .DEPTH (SLOTS)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // Output register: load on take, drop valid once the request is delivered.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_addr_nxt  = out_addr_r;
    out_sts_nxt   = out_sts_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (rsp_take) begin
      out_valid_nxt = 1'b1;
      out_addr_nxt  = rsp.block_addr;
      out_sts_nxt   = rsp.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_addr_r <= out_addr_nxt;
    out_sts_r  <= out_sts_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_block_addr = out_addr_r;
  assign out_status     = out_sts_r;

  // A request, once taken, keeps the block busy in the next cycle.
  `BBA_ASSERT_NEXT(a_busy_after_take, in_fire, !in_ready, "ready right after a request")
  // A finished result waits in the sequencer until the output register takes it.
  `BBA_ASSERT_NEXT(a_rsp_held, ctl_out.rsp_valid && !rsp_take, ctl_out.rsp_valid, "result lost")
  // A failed result carries address zero; free results are zeroed as well by the sequencer.
  `BBA_ASSERT_IMPL(a_zero_addr, out_valid && out_status != STS_OK, out_block_addr == '0, "bad addr")

endmodule

@@ tb/buddy_block_allocator_checker.sv @@
module buddy_block_allocator_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_mode,
  input  logic [15:0] in_alloc_size,
  input  logic [9:0]  in_free_addr,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [9:0]  out_block_addr,
  input  logic [1:0]  out_status,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int MINO = 4;
  localparam int MAXO = 10;
  localparam int NORD = MAXO - MINO + 1;
  localparam int SLOTS = 1 << (MAXO - MINO);

  // free lists as per-order queues; index 0 is the bottom, last is the head
  logic [9:0] pool_list [NORD][$];
  logic [3:0] order_map [SLOTS];
  bba_rsp_t   rsp_q [$];

  task automatic pool_reset();
    for (int i = 0; i < NORD; i++) pool_list[i].delete();
    for (int i = 0; i < SLOTS; i++) order_map[i] = '0;
    pool_list[NORD-1].push_back(10'd0);
  endtask

  // remove the entry nearest the head matching addr; return whether found
  function automatic bit list_take(int lv, logic [9:0] a);
    for (int i = pool_list[lv].size() - 1; i >= 0; i--)
      if (pool_list[lv][i] == a) begin
        pool_list[lv].delete(i);
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function automatic bba_rsp_t alloc_block(logic [15:0] size);
    bba_rsp_t r;
    int o, lv, k;
    logic [9:0] a;
    r = '0;
    o = MINO;
    while (o <= MAXO && (1 << o) < size) o++;
    if (o > MAXO) begin
      r.status = STS_NO_BLOCK;
      return r;
    end
    lv = o - MINO;
    k = lv;
    while (k < NORD && pool_list[k].size() == 0) k++;
    if (k >= NORD) begin
      r.status = STS_NO_BLOCK;
      return r;
    end
    a = pool_list[k].pop_back();
    while (k > lv) begin
      k--;
      pool_list[k].push_back(a + 10'(1 << (k + MINO)));
    end
    order_map[a >> MINO] = 4'(lv + 1);
    r.block_addr = a;
    r.status = STS_OK;
    return r;
  endfunction

  function automatic bba_rsp_t free_block(logic [9:0] addr);
    bba_rsp_t r;
    int lv;
    logic [9:0] bud, low;
    r = '0;
    if (addr[MINO-1:0] != 0 || order_map[addr >> MINO] == 0 ||
        order_map[addr >> MINO] > NORD) begin
      r.status = STS_BAD_ADDR;
      return r;
    end
    lv = order_map[addr >> MINO] - 1;
    order_map[addr >> MINO] = '0;
    pool_list[lv].push_back(addr);
    while (lv + 1 < NORD) begin
      bud = addr ^ 10'(1 << (lv + MINO));
      if (!list_take(lv, bud)) break;
      void'(list_take(lv, addr));
      low = addr < bud ? addr : bud;
      lv++;
      pool_list[lv].push_back(low);
      addr = low;
    end
    r.status = STS_OK;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    pool_reset();
  end

  always @(posedge clk) begin
    bba_rsp_t want;
    if (!rst_n) begin
      pool_reset();
      rsp_q.delete();
    end else begin
      if (in_valid && in_ready)
        rsp_q.push_back(in_mode == MODE_ALLOC ? alloc_block(in_alloc_size)
                                              : free_block(in_free_addr));
      if (out_valid && out_ready) begin
        if (rsp_q.size() == 0) begin
          $error("unexpected result block_addr=%0d status=%0d", out_block_addr, out_status);
          fail_count++;
        end else begin
          want = rsp_q.pop_front();
          if (out_block_addr !== want.block_addr) begin
            $error("block_addr expected %0d actual %0d", want.block_addr, out_block_addr);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_status);
            fail_count++;
          end
        end
      end
    end
    pending = rsp_q.size();
  end
endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = MODE_ALLOC;
  logic [15:0] in_alloc_size = '0;
  logic [9:0]  in_free_addr = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  out_block_addr;
  logic [1:0]  out_status;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;

  // addresses of blocks the stimulus believes are live, used to aim frees
  logic [9:0]  live_blocks [$];

  localparam int WATCHDOG = 20000;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  buddy_block_allocator_unit dut (.*);

  buddy_block_allocator_checker chk (.*);

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // drive one request and hold it until accepted; step past the edge that
  // dropped the previous valid before raising the next one
  task automatic send_req(logic m, logic [15:0] sz, logic [9:0] fa);
    int g;
    g = gap_len();
    repeat (g + 1) @(posedge clk);
    in_valid      <= 1'b1;
    in_mode       <= m;
    in_alloc_size <= sz;
    in_free_addr  <= fa;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
  endtask

  // wait, sampling between edges, until every expected result is back
  task automatic drain();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic alloc_req(logic [15:0] sz);
    send_req(MODE_ALLOC, sz, 10'($urandom));
  endtask

  task automatic free_req(logic [9:0] fa);
    send_req(MODE_FREE, 16'($urandom), fa);
  endtask

  // free a random live block, or a stray address if none is tracked
  task automatic free_some_live();
    int i;
    logic [9:0] a;
    if (live_blocks.size() == 0) begin
      free_req(10'($urandom));
    end else begin
      i = $urandom_range(0, live_blocks.size() - 1);
      a = live_blocks[i];
      live_blocks.delete(i);
      free_req(a);
    end
  endtask

  // random size biased toward small blocks that fit the pool
  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'($urandom);
    if (r < 10) return 16'd0;
    if (r < 80) return 16'($urandom_range(1, 64));
    return 16'($urandom_range(65, 1024));
  endfunction

  // capture allocated addresses so later frees hit live blocks
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready && out_status == STS_OK && out_block_addr != 0)
      live_blocks.push_back(out_block_addr);
  end

  // receiver stalls: random length, with stretches of always-ready
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      g = gap_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // watchdog: count cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    int r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: whole pool, zero size, oversize, double, misaligned and unallocated frees
    alloc_req(16'd1024);
    alloc_req(16'd1);
    free_req(10'd0);
    alloc_req(16'd0);
    alloc_req(16'd1025);
    alloc_req(16'hFFFF);
    free_req(10'd0);
    free_req(10'd0);
    free_req(10'd8);
    free_req(10'h3FF);
    free_req(10'h3F0);
    for (int i = 0; i < 6; i++) alloc_req(16'd16);
    alloc_req(16'd17);
    alloc_req(16'd512);
    alloc_req(16'd512);
    drain();
    while (live_blocks.size() != 0 || pending != 0) begin
      if (pending != 0) @(negedge clk);
      else free_some_live();
    end
    free_req(10'd0);

    // hold off until every result is back
    drain();

    // random: mostly alloc/free of live blocks, some noise
    for (int n = 0; n < 750; n++) begin
      r = $urandom_range(0, 99);
      if (r < 50) alloc_req(pick_size());
      else if (r < 90) free_some_live();
      else free_req(10'($urandom));
      if (n == 400) drain();
    end

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+design
design/bba_pkg.sv
design/bba_ram.sv
design/bba_seq.sv
design/buddy_block_allocator_unit.sv
tb/buddy_block_allocator_checker.sv
tb/testbench.sv
